// File: sv/assert_macros.svh
// Assertion macros used by the checker module of the project.
// No dependencies; include this file by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define LTS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define LTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: sv/lts_pkg.sv
// Package of the lottery ticket scheduler: sizes, opcodes, state codes and
// the command and status records between controller and datapath. No dependencies.
package lts_pkg;

   localparam int TICKET_SPACE  = 128;
   localparam int PROCESS_COUNT = 16;
   localparam int RANDOM_BITS   = 16;

   // Fixed field widths of the channels.
   localparam int TICKET_W = 7;
   localparam int PROC_W   = $clog2(PROCESS_COUNT);
   localparam int RAND_W   = 16;

   // Ticket index, scan counter (can hold TICKET_SPACE), held count, divider steps.
   localparam int TIDX_W = $clog2(TICKET_SPACE);
   localparam int SCAN_W = $clog2(TICKET_SPACE + 1);
   localparam int HELD_W = $clog2(TICKET_SPACE + 1);
   localparam int STEP_W = $clog2(RANDOM_BITS);

   localparam logic OPC_REGISTER = 1'b0;
   localparam logic OPC_DONE     = 1'b1;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_START   = 8'b0000_0010,
      ST_RELEASE = 8'b0000_0100,
      ST_DECIDE  = 8'b0000_1000,
      ST_DIVIDE  = 8'b0001_0000,
      ST_SEARCH  = 8'b0010_0000,
      ST_OWNER   = 8'b0100_0000,
      ST_EMPTY   = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic reg_write;     // record a ticket from the input beat
      logic latch;         // capture a done item
      logic scan_clear;    // rewind the ticket scan
      logic release_step;  // one step of the release scan
      logic div_init;      // load the divider and rewind the scan
      logic div_step;      // one restoring division step
      logic search_step;   // one step of the rank search
      logic load_result;   // load a drawn ticket into the output register
      logic load_idle;     // load an idle result into the output register
   } cmd_type;

   typedef struct packed {
      logic last;          // captured item releases its tickets
      logic held_zero;     // no ticket is held
      logic release_done;  // release scan checked the final ticket
      logic div_done;      // the current division step is the final one
      logic found;         // the scan points at the ticket of the drawn rank
      logic out_free;      // output register can take a result
   } status_type;

endpackage

// File: sv/lts_if.sv
// Valid/ready channel interfaces of the lottery ticket scheduler.
// Depends on lts_pkg for field widths.
interface lts_req_if;
   logic                          valid;
   logic                          ready;
   logic                          opcode;
   logic [lts_pkg::TICKET_W-1:0]  ticket;
   logic [lts_pkg::PROC_W-1:0]    process;
   logic                          last_instruction;
   logic [lts_pkg::RAND_W-1:0]    random_value;

   modport source (output valid, opcode, ticket, process, last_instruction, random_value,
                   input ready);
   modport sink   (input valid, opcode, ticket, process, last_instruction, random_value,
                   output ready);
endinterface

interface lts_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lts_pkg::PROC_W-1:0]    next_process;
   logic [lts_pkg::TICKET_W-1:0]  drawn_ticket;
   logic                          idle;

   modport source (output valid, next_process, drawn_ticket, idle, input ready);
   modport sink   (input valid, next_process, drawn_ticket, idle, output ready);
endinterface

// File: sv/lottery_ticket_scheduler.sv
// Lottery ticket scheduler: a table of 128 tickets, each free or held by one
// of 16 processes, and a draw that picks the next process to run.
// Input channel req_ch: opcode 0 records a ticket and its owner and gives no
// result; the block is ready again in the next cycle.
// Opcode 1 says a process finished an instruction; with last_instruction set,
// every ticket that process holds is freed first. The block then takes
// random_value modulo the held count as a rank and reports the held ticket of
// that rank in ascending order, with its owner, on rsp_ch; with no ticket
// held it reports idle with zero fields.
// A done item runs 16 restoring division steps and then a scan of the valid
// bits one ticket per cycle; with last_instruction set, a release pass before
// them reads the owner RAM one ticket per cycle. When no ticket is held after
// any release, the draw is skipped and an idle result is given.
// Done items are worked one at a time; ready is low while one is in progress.
// Results sit in an output register; if rsp_ch stalls, the block holds the
// result and can still take register beats, and a finished draw waits until
// the register frees. Reset frees every ticket and empties the output.
module lottery_ticket_scheduler (
   input  logic      clock,
   input  logic      reset,
   lts_req_if.sink   req_ch,
   lts_rsp_if.source rsp_ch
);

   lts_pkg::cmd_type    cmd;
   lts_pkg::status_type status;

   lts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_opcode (req_ch.opcode),
      .req_ready  (req_ch.ready),
      .status     (status),
      .cmd        (cmd)
   );

   lts_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_ticket           (req_ch.ticket),
      .req_process          (req_ch.process),
      .req_last_instruction (req_ch.last_instruction),
      .req_random_value     (req_ch.random_value),
      .rsp_valid            (rsp_ch.valid),
      .rsp_ready            (rsp_ch.ready),
      .rsp_next_process     (rsp_ch.next_process),
      .rsp_drawn_ticket     (rsp_ch.drawn_ticket),
      .rsp_idle             (rsp_ch.idle)
   );

endmodule

// File: sv/lts_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/lts_ctrl.sv
// Controller state machine of the lottery ticket scheduler.
// Depends on lts_pkg for the state, command and status types.
module lts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_opcode,
   output logic                req_ready,
   input  lts_pkg::status_type status,
   output lts_pkg::cmd_type    cmd
);

   lts_pkg::state_type state_ff, state_in;

   // Register beats in idle; one done item: release, divide, search, deliver or idle.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = (state_ff == lts_pkg::ST_IDLE);
      case (state_ff)
         lts_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == lts_pkg::OPC_DONE) begin
                  cmd.latch = 1'b1;
                  state_in  = lts_pkg::ST_START;
               end else begin
                  cmd.reg_write = 1'b1;
               end
            end
         end
         lts_pkg::ST_START: begin
            cmd.scan_clear = 1'b1;
            state_in = status.last ? lts_pkg::ST_RELEASE : lts_pkg::ST_DECIDE;
         end
         lts_pkg::ST_RELEASE: begin
            cmd.release_step = 1'b1;
            if (status.release_done) begin
               state_in = lts_pkg::ST_DECIDE;
            end
         end
         lts_pkg::ST_DECIDE: begin
            if (status.held_zero) begin
               state_in = lts_pkg::ST_EMPTY;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = lts_pkg::ST_DIVIDE;
            end
         end
         lts_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = lts_pkg::ST_SEARCH;
            end
         end
         lts_pkg::ST_SEARCH: begin
            cmd.search_step = 1'b1;
            if (status.found) begin
               state_in = lts_pkg::ST_OWNER;
            end
         end
         lts_pkg::ST_OWNER: begin
            if (status.out_free) begin
               cmd.load_result = 1'b1;
               state_in        = lts_pkg::ST_IDLE;
            end
         end
         lts_pkg::ST_EMPTY: begin
            if (status.out_free) begin
               cmd.load_idle = 1'b1;
               state_in      = lts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lts_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sv/lts_dp.sv
// Datapath of the lottery ticket scheduler: ticket table, divider, rank
// search and output register. Depends on lts_pkg and lts_ram.
module lts_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  lts_pkg::cmd_type              cmd,
   output lts_pkg::status_type           status,
   input  logic [lts_pkg::TICKET_W-1:0]  req_ticket,
   input  logic [lts_pkg::PROC_W-1:0]    req_process,
   input  logic                          req_last_instruction,
   input  logic [lts_pkg::RAND_W-1:0]    req_random_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lts_pkg::PROC_W-1:0]    rsp_next_process,
   output logic [lts_pkg::TICKET_W-1:0]  rsp_drawn_ticket,
   output logic                          rsp_idle
);

   // Captured done item.
   logic [lts_pkg::PROC_W-1:0]       proc_ff;
   logic                             last_ff;
   logic [lts_pkg::RANDOM_BITS-1:0]  dvd_ff, dvd_in;

   // Ticket table state.
   logic [lts_pkg::TICKET_SPACE-1:0] valid_ff, valid_in;
   logic [lts_pkg::HELD_W-1:0]       held_ff, held_in;

   // Scan counter and the release check stage behind the owner RAM.
   logic [lts_pkg::SCAN_W-1:0]       scan_ff, scan_in;
   logic                             chk_ff, chk_in;
   logic [lts_pkg::TIDX_W-1:0]       chk_idx_ff;
   logic [lts_pkg::TIDX_W-1:0]       scan_idx;
   logic                             scan_lt;

   // Divider and search.
   logic [lts_pkg::HELD_W-1:0]       rem_ff, rem_in;
   logic [lts_pkg::STEP_W-1:0]       step_ff, step_in;
   logic [lts_pkg::HELD_W-1:0]       seen_ff, seen_in;
   logic [lts_pkg::HELD_W:0]         shifted;

   // Output register.
   logic                             out_valid_ff, out_valid_in;
   logic [lts_pkg::PROC_W-1:0]       out_proc_ff;
   logic [lts_pkg::TICKET_W-1:0]     out_ticket_ff;
   logic                             out_idle_ff;

   logic [lts_pkg::PROC_W-1:0]       owner_rd;
   logic                             in_range;
   logic                             release_hit;
   logic                             found;
   logic                             out_free;

   assign scan_idx = scan_ff[lts_pkg::TIDX_W-1:0];
   assign scan_lt  = (32'(scan_ff) < lts_pkg::TICKET_SPACE);
   assign in_range = (32'(req_ticket) < lts_pkg::TICKET_SPACE);

   // Owner store, read at the scan position every cycle.
   lts_ram #(
      .WIDTH (lts_pkg::PROC_W),
      .DEPTH (lts_pkg::TICKET_SPACE)
   ) u_owner_ram (
      .clock   (clock),
      .wr_en   (cmd.reg_write && in_range),
      .wr_addr (req_ticket[lts_pkg::TIDX_W-1:0]),
      .wr_data (req_process),
      .rd_addr (scan_idx),
      .rd_data (owner_rd)
   );

   assign release_hit = chk_ff && valid_ff[chk_idx_ff] && (owner_rd == proc_ff);
   assign found       = valid_ff[scan_idx] && (seen_ff == rem_ff);
   assign out_free    = !out_valid_ff || rsp_ready;

   // Valid bits and held count: set by registration, cleared by release.
   always_comb begin
      valid_in = valid_ff;
      held_in  = held_ff;
      if (cmd.reg_write && in_range) begin
         if (!valid_ff[req_ticket[lts_pkg::TIDX_W-1:0]]) begin
            held_in = held_ff + 1'b1;
         end
         valid_in[req_ticket[lts_pkg::TIDX_W-1:0]] = 1'b1;
      end
      if (release_hit) begin
         valid_in[chk_idx_ff] = 1'b0;
         held_in = held_ff - 1'b1;
      end
   end

   // Scan counter shared by the release pass and the rank search.
   always_comb begin
      scan_in = scan_ff;
      seen_in = seen_ff;
      chk_in  = 1'b0;
      if (cmd.scan_clear || cmd.div_init) begin
         scan_in = '0;
         seen_in = '0;
      end else if (cmd.release_step) begin
         chk_in = scan_lt;
         if (scan_lt) begin
            scan_in = scan_ff + 1'b1;
         end
      end else if (cmd.search_step && !found && scan_lt) begin
         scan_in = scan_ff + 1'b1;
         if (valid_ff[scan_idx]) begin
            seen_in = seen_ff + 1'b1;
         end
      end
   end

   // Restoring division: one quotient bit per step, remainder kept.
   always_comb begin
      shifted = {rem_ff, dvd_ff[lts_pkg::RANDOM_BITS-1]};
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      step_in = step_ff;
      if (cmd.latch) begin
         dvd_in = req_random_value[lts_pkg::RANDOM_BITS-1:0];
      end else if (cmd.div_init) begin
         rem_in  = '0;
         step_in = '0;
      end else if (cmd.div_step) begin
         dvd_in  = {dvd_ff[lts_pkg::RANDOM_BITS-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (shifted >= {1'b0, held_ff}) begin
            rem_in = lts_pkg::HELD_W'(shifted - {1'b0, held_ff});
         end else begin
            rem_in = shifted[lts_pkg::HELD_W-1:0];
         end
      end
   end

   // Output register valid flag.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.load_result || cmd.load_idle) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         held_ff      <= '0;
         chk_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         held_ff      <= held_in;
         chk_ff       <= chk_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         proc_ff <= req_process;
         last_ff <= req_last_instruction;
      end
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      step_ff    <= step_in;
      scan_ff    <= scan_in;
      seen_ff    <= seen_in;
      chk_idx_ff <= scan_idx;
      if (cmd.load_result) begin
         out_proc_ff   <= owner_rd;
         out_ticket_ff <= lts_pkg::TICKET_W'(scan_idx);
         out_idle_ff   <= 1'b0;
      end else if (cmd.load_idle) begin
         out_proc_ff   <= '0;
         out_ticket_ff <= '0;
         out_idle_ff   <= 1'b1;
      end
   end

   assign status.last         = last_ff;
   assign status.held_zero    = (held_ff == '0);
   assign status.release_done = chk_ff
                                && (32'(chk_idx_ff) == lts_pkg::TICKET_SPACE - 1);
   assign status.div_done     = (32'(step_ff) == lts_pkg::RANDOM_BITS - 1);
   assign status.found        = found;
   assign status.out_free     = out_free;

   assign rsp_valid        = out_valid_ff;
   assign rsp_next_process = out_proc_ff;
   assign rsp_drawn_ticket = out_ticket_ff;
   assign rsp_idle         = out_idle_ff;

endmodule

// File: sv/lts_checker.sv
// Port-level checker of the lottery ticket scheduler and its bind.
// Depends on assert_macros.svh, lts_pkg and lottery_ticket_scheduler.
`include "assert_macros.svh"

module lts_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_opcode,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [lts_pkg::PROC_W-1:0]    rsp_next_process,
   input logic [lts_pkg::TICKET_W-1:0]  rsp_drawn_ticket,
   input logic                          rsp_idle
);

   // A stalled result beat keeps its payload.
   `LTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_next_process) && $stable(rsp_drawn_ticket) && $stable(rsp_idle))

   // An idle result carries zero process and ticket fields.
   `LTS_ASSERT_SAME(a_idle_zero, clock, reset, rsp_valid && rsp_idle, rsp_next_process == '0 && rsp_drawn_ticket == '0)

   // A done beat occupies the block in the next cycle.
   `LTS_ASSERT_NEXT(a_done_busy, clock, reset, req_valid && req_ready && req_opcode == lts_pkg::OPC_DONE, !req_ready)

   // A register beat leaves the block ready in the next cycle.
   `LTS_ASSERT_NEXT(a_reg_ready, clock, reset, req_valid && req_ready && req_opcode == lts_pkg::OPC_REGISTER, req_ready)

endmodule

bind lottery_ticket_scheduler lts_checker u_lts_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .req_opcode       (req_ch.opcode),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_next_process (rsp_ch.next_process),
   .rsp_drawn_ticket (rsp_ch.drawn_ticket),
   .rsp_idle         (rsp_ch.idle)
);

// File: tb/tb_lottery_ticket_scheduler.sv
// Testbench of the lottery ticket scheduler: a clocked driver and monitor around the block.
// It predicts every draw from its own ticket table and checks each result beat.
// Depends on lts_pkg, lts_if.sv and lottery_ticket_scheduler.sv.
module tb_lottery_ticket_scheduler;
   timeunit 1ns;
   timeprecision 1ps;

   // One beat of the request channel.
   typedef struct packed {
      logic                         opcode;
      logic [lts_pkg::TICKET_W-1:0] ticket;
      logic [lts_pkg::PROC_W-1:0]   owner;
      logic                         last_instruction;
      logic [lts_pkg::RAND_W-1:0]   random_value;
   } sched_beat_type;

   // One beat of the result channel.
   typedef struct packed {
      logic [lts_pkg::PROC_W-1:0]   next_process;
      logic [lts_pkg::TICKET_W-1:0] drawn_ticket;
      logic                         idle;
   } draw_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lts_req_if req_ch ();
   lts_rsp_if rsp_ch ();

   lottery_ticket_scheduler dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Pending request beats and the draws we expect back, oldest first.
   sched_beat_type beat_q[$];
   draw_type       draw_q[$];

   // Our own copy of the ticket table.
   bit                         ticket_held[lts_pkg::TICKET_SPACE];
   logic [lts_pkg::PROC_W-1:0] ticket_owner_of[lts_pkg::TICKET_SPACE];
   int                         held_total = 0;

   int             mismatch_count = 0;
   int             beats_taken = 0;
   int             draws_seen = 0;
   int             hold_left = 0;
   bit             hold_used = 1'b0;
   sched_beat_type send_beat;
   sched_beat_type seen_beat;
   draw_type       got_draw;
   draw_type       want_draw;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("mismatch at %0t: %s expected %0d, got %0d", $realtime, what, want, got);
      mismatch_count++;
   endtask

   // Append one beat to the stimulus queue.
   task automatic queue_beat(input sched_beat_type b);
      beat_q = {beat_q, b};
   endtask

   // Apply one accepted beat to the ticket table and queue the draw it causes.
   task automatic predict_beat(input sched_beat_type b);
      int       rnd;
      int       rank;
      int       seen;
      int       winner;
      draw_type d;
      if (b.opcode == lts_pkg::OPC_REGISTER) begin
         if (!ticket_held[b.ticket]) begin
            ticket_held[b.ticket] = 1'b1;
            held_total++;
         end
         ticket_owner_of[b.ticket] = b.owner;
      end else begin
         // A final instruction frees every ticket the process currently owns.
         if (b.last_instruction) begin
            for (int t = 0; t < lts_pkg::TICKET_SPACE; t++) begin
               if (ticket_held[t] && ticket_owner_of[t] == b.owner) begin
                  ticket_held[t] = 1'b0;
                  held_total--;
               end
            end
         end
         if (held_total == 0) begin
            d.next_process = '0;
            d.drawn_ticket = '0;
            d.idle = 1'b1;
         end else begin
            // The rank counts held tickets in ascending ticket order.
            rnd = int'(b.random_value) & ((1 << lts_pkg::RANDOM_BITS) - 1);
            rank = rnd % held_total;
            seen = 0;
            winner = 0;
            for (int t = 0; t < lts_pkg::TICKET_SPACE; t++) begin
               if (ticket_held[t]) begin
                  if (seen == rank) begin
                     winner = t;
                     break;
                  end
                  seen++;
               end
            end
            d.next_process = ticket_owner_of[winner];
            d.drawn_ticket = winner[lts_pkg::TICKET_W-1:0];
            d.idle = 1'b0;
         end
         draw_q = {draw_q, d};
      end
   endtask

   function automatic sched_beat_type make_register(input int t, input int p);
      sched_beat_type b;
      b.opcode = lts_pkg::OPC_REGISTER;
      b.ticket = t[lts_pkg::TICKET_W-1:0];
      b.owner = p[lts_pkg::PROC_W-1:0];
      // Fields a register beat ignores still carry random bits.
      b.last_instruction = 1'($urandom_range(0, 1));
      b.random_value = lts_pkg::RAND_W'($urandom_range(0, 65535));
      return b;
   endfunction

   function automatic sched_beat_type make_done(input int p, input bit last, input int rnd);
      sched_beat_type b;
      b.opcode = lts_pkg::OPC_DONE;
      b.ticket = lts_pkg::TICKET_W'($urandom_range(0, lts_pkg::TICKET_SPACE - 1));
      b.owner = p[lts_pkg::PROC_W-1:0];
      b.last_instruction = last;
      b.random_value = rnd[lts_pkg::RAND_W-1:0];
      return b;
   endfunction

   // Driver: offers the next queued beat once the current one is taken.
   // No gaps while beats 150 through 259 go out.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (beat_q.size() != 0 &&
             ((beats_taken >= 150 && beats_taken < 260) || $urandom_range(0, 99) >= 12)) begin
            send_beat = beat_q.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.opcode <= send_beat.opcode;
            req_ch.ticket <= send_beat.ticket;
            req_ch.process <= send_beat.owner;
            req_ch.last_instruction <= send_beat.last_instruction;
            req_ch.random_value <= send_beat.random_value;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Long hold-off of the result channel once 25 draws have come back,
   // so that a finished draw fills the output and the input stalls.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_used <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_used && draws_seen >= 25) begin
         hold_left <= 3000;
         hold_used <= 1'b1;
      end
   end

   // Receiver: random stalls, none while draws 40 through 79 come back.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= (hold_left == 0) &&
                         ((draws_seen >= 40 && draws_seen < 80) ||
                          $urandom_range(0, 99) >= 12);
      end
   end

   // Monitor: predicts on each accepted request beat and checks each result beat.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            seen_beat.opcode = req_ch.opcode;
            seen_beat.ticket = req_ch.ticket;
            seen_beat.owner = req_ch.process;
            seen_beat.last_instruction = req_ch.last_instruction;
            seen_beat.random_value = req_ch.random_value;
            predict_beat(seen_beat);
            beats_taken <= beats_taken + 1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_draw.next_process = rsp_ch.next_process;
            got_draw.drawn_ticket = rsp_ch.drawn_ticket;
            got_draw.idle = rsp_ch.idle;
            draws_seen <= draws_seen + 1;
            if (draw_q.size() == 0) begin
               report_mismatch("result beats waiting", 0, 1);
            end else begin
               want_draw = draw_q.pop_front();
               if (got_draw.idle !== want_draw.idle)
                  report_mismatch("idle", int'(want_draw.idle), int'(got_draw.idle));
               if (got_draw.next_process !== want_draw.next_process)
                  report_mismatch("next_process", int'(want_draw.next_process),
                                  int'(got_draw.next_process));
               if (got_draw.drawn_ticket !== want_draw.drawn_ticket)
                  report_mismatch("drawn_ticket", int'(want_draw.drawn_ticket),
                                  int'(got_draw.drawn_ticket));
            end
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin : stimulus
      int n_reg;
      int n_done;
      req_ch.valid = 1'b0;
      req_ch.opcode = lts_pkg::OPC_REGISTER;
      req_ch.ticket = '0;
      req_ch.process = '0;
      req_ch.last_instruction = 1'b0;
      req_ch.random_value = '0;
      rsp_ch.ready = 1'b0;

      // Draws from an empty table, with and without a release.
      queue_beat(make_done(0, 1'b0, 0));
      queue_beat(make_done(15, 1'b1, 65535));
      // Tickets at both ends of the table and both ends of the owner range.
      queue_beat(make_register(0, 15));
      queue_beat(make_register(127, 0));
      queue_beat(make_register(64, 7));
      queue_beat(make_done(3, 1'b0, 0));
      queue_beat(make_done(3, 1'b0, 65535));
      queue_beat(make_done(3, 1'b0, 1));
      // Registering a held ticket again only changes its owner.
      queue_beat(make_register(0, 9));
      queue_beat(make_done(9, 1'b0, 0));
      // A ticket taken over by another process survives the old owner's release.
      queue_beat(make_register(64, 9));
      queue_beat(make_done(7, 1'b1, 1));
      queue_beat(make_done(9, 1'b1, 0));
      // Releasing the last holder empties the table again.
      queue_beat(make_done(0, 1'b1, 5));

      // Rounds of registrations followed by draws; now and then a large fill
      // and now and then every process finishing.
      while (beat_q.size() < 450) begin
         n_reg = ($urandom_range(0, 99) < 10) ? $urandom_range(40, 100)
                                               : $urandom_range(1, 12);
         repeat (n_reg)
            queue_beat(make_register($urandom_range(0, lts_pkg::TICKET_SPACE - 1),
                                     $urandom_range(0, 15)));
         n_done = $urandom_range(1, 8);
         repeat (n_done)
            queue_beat(make_done($urandom_range(0, 15),
                                 $urandom_range(0, 3) == 0,
                                 $urandom_range(0, 65535)));
         if ($urandom_range(0, 14) == 0) begin
            for (int p = 0; p < lts_pkg::PROCESS_COUNT; p++)
               queue_beat(make_done(p, 1'b1, $urandom_range(0, 65535)));
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Wait for every beat to go out, every draw to return, then some quiet time.
      @(posedge clock);
      while (beat_q.size() != 0 || req_ch.valid)
         @(posedge clock);
      while (draw_q.size() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Hard limit on the run time.
   initial begin
      #20000000;
      $display("status: fail");
      $finish;
   end

endmodule
